// ===== rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int CW       = 32;
	localparam int FRAC_DEF = 16;
	localparam int DW       = 2 * CW + 2;

	typedef logic [1:0] cnt_t;

	localparam cnt_t CNT_NONE = 2'd0;
	localparam cnt_t CNT_ONE  = 2'd1;
	localparam cnt_t CNT_TWO  = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] coeff_a;
		logic signed [CW-1:0] coeff_b;
		logic signed [CW-1:0] coeff_c;
	} in_t;

	typedef struct packed {
		cnt_t                 root_count;
		logic signed [CW-1:0] root_first;
		logic signed [CW-1:0] root_second;
		logic                 saturated;
	} out_t;

	typedef struct packed {
		logic          lin;
		logic          dneg;
		logic          dzero;
		logic          sa;
		logic          sb;
		logic          sc;
		logic [CW-1:0] ma;
		logic [CW-1:0] mb;
		logic [CW-1:0] mc;
	} front_t;

	typedef struct packed {
		cnt_t cnt;
		logic neg1;
		logic neg2;
	} div_side_t;

endpackage

// ===== rtl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*t^2 + b*t + c in signed fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one coefficient transaction is accepted every clock while
// in_ready is high; it drops while the skid entry is full. Each result passes
// through 3 front stages, 33 square-root stages (one root bit each), one
// numerator stage, 34+FRAC_BITS divider stages (one quotient bit each) and
// the output register. A two-entry output register lets the pipe advance
// once more when the consumer stalls; after that it holds until out_ready
// returns.
module quadratic_root_solver #(
	parameter int FRAC_BITS = qrs_pkg::FRAC_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qrs_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output qrs_pkg::out_t out_data
);
	import qrs_pkg::*;

	localparam int NW = CW + 2 + FRAC_BITS;
	localparam logic [NW-1:0] LIM = NW'(1) << (CW - 1);

	function automatic logic [CW+2:0] sm_add(input logic sx, input logic [CW+1:0] mx,
		input logic sy, input logic [CW+1:0] my);
		logic          s;
		logic [CW+1:0] m;
		if (sx == sy) begin
			s = sx;
			m = mx + my;
		end else if (mx >= my) begin
			s = sx;
			m = mx - my;
		end else begin
			s = sy;
			m = my - mx;
		end
		if (m == '0) s = 1'b0;
		return {s, m};
	endfunction

	function automatic logic [CW:0] make_root(input logic neg, input logic [NW-1:0] q);
		logic          sat;
		logic [CW-1:0] v;
		sat = 1'b0;
		v   = q[CW-1:0];
		if (neg) begin
			if (q > LIM) begin
				sat = 1'b1;
				v   = LIM[CW-1:0];
			end
			v = ~v + 1'b1;
		end else if (q > LIM - 1'b1) begin
			sat = 1'b1;
			v   = CW'(LIM - 1'b1);
		end
		return {sat, v};
	endfunction

	logic          en;
	logic          fv, sv, dv;
	front_t        fside, sside;
	logic [DW-1:0] fdisc;
	logic [CW:0]   sroot;

	logic          v_num;
	div_side_t     side_num;
	logic [CW+1:0] m1_num, m2_num;
	logic [CW:0]   den_num;

	div_side_t     dside;
	logic [NW-1:0] q1, q2;

	logic          out_valid_q, skid_v_q;
	out_t          out_q, skid_q, fmt;
	logic [CW:0]   rt1, rt2;
	logic          take_out;

	logic          nb_neg;
	logic [CW+2:0] a1, a2;
	cnt_t          cnt_c;

	assign en       = !skid_v_q;
	assign in_ready = en;

	qrs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (in_valid),
		.din    (in_data),
		.vout   (fv),
		.side   (fside),
		.disc   (fdisc)
	);

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (fv),
		.side_in  (fside),
		.rad_in   (fdisc),
		.vout     (sv),
		.side_out (sside),
		.root     (sroot)
	);

	assign nb_neg = !sside.sb && (sside.mb != '0);
	assign a1 = sm_add(nb_neg, {2'b00, sside.mb}, 1'b1, {1'b0, sroot});
	assign a2 = sm_add(nb_neg, {2'b00, sside.mb}, 1'b0, {1'b0, sroot});

	always_comb begin
		if (sside.lin) begin
			cnt_c = (sside.mb != '0) ? CNT_ONE : CNT_NONE;
		end else if (sside.dneg) begin
			cnt_c = CNT_NONE;
		end else if (sside.dzero) begin
			cnt_c = CNT_ONE;
		end else begin
			cnt_c = CNT_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_num <= 1'b0;
		end else if (en) begin
			v_num <= sv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_num.cnt <= cnt_c;
			if (sside.lin) begin
				side_num.neg1 <= (sside.mc != '0) && (sside.sc == sside.sb);
				side_num.neg2 <= 1'b0;
				m1_num        <= {2'b00, sside.mc};
				m2_num        <= '0;
				den_num       <= {1'b0, sside.mb};
			end else begin
				side_num.neg1 <= (a1[CW+2] != sside.sa) && (a1[CW+1:0] != '0);
				side_num.neg2 <= (a2[CW+2] != sside.sa) && (a2[CW+1:0] != '0);
				m1_num        <= a1[CW+1:0];
				m2_num        <= a2[CW+1:0];
				den_num       <= {sside.ma, 1'b0};
			end
		end
	end

	qrs_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_num),
		.side_in  (side_num),
		.mag1     (m1_num),
		.mag2     (m2_num),
		.den      (den_num),
		.vout     (dv),
		.side_out (dside),
		.quo1     (q1),
		.quo2     (q2)
	);

	assign rt1 = make_root(dside.neg1, q1);
	assign rt2 = make_root(dside.neg2, q2);

	always_comb begin
		fmt.root_count  = dside.cnt;
		fmt.root_first  = '0;
		fmt.root_second = '0;
		fmt.saturated   = 1'b0;
		if (dside.cnt != CNT_NONE) begin
			fmt.root_first = rt1[CW-1:0];
			fmt.saturated  = rt1[CW];
		end
		if (dside.cnt == CNT_TWO) begin
			fmt.root_second = rt2[CW-1:0];
			fmt.saturated   = rt1[CW] || rt2[CW];
		end
	end

	assign take_out = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (take_out) begin
			if (skid_v_q) begin
				out_valid_q <= 1'b1;
				skid_v_q    <= 1'b0;
			end else begin
				out_valid_q <= dv;
			end
		end else if (dv) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			out_q <= skid_v_q ? skid_q : fmt;
		end else if (!skid_v_q) begin
			skid_q <= fmt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid_q)
		else $error("skid entry without output entry");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.root_count == CNT_NONE || out_q.root_count == CNT_ONE ||
			out_q.root_count == CNT_TWO))
		else $error("root count out of range");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.root_count == CNT_NONE) |->
			(out_q.root_first == '0 && out_q.root_second == '0 && !out_q.saturated))
		else $error("roots reported with zero count");

	a_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.root_count != CNT_TWO) |-> (out_q.root_second == '0))
		else $error("second root set without two roots");

endmodule

// ===== rtl/qrs_front.sv =====
// ----------------------------------------------------------------------------
// qrs_front
// Sign split, squaring/product and discriminant, three stages.
// ----------------------------------------------------------------------------
module qrs_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vin,
	input  qrs_pkg::in_t                 din,
	output logic                         vout,
	output qrs_pkg::front_t              side,
	output logic [qrs_pkg::DW-1:0]       disc
);
	import qrs_pkg::*;

	logic          v_s1, v_s2, v_s3;
	logic          sa_s1, sb_s1, sc_s1;
	logic [CW-1:0] ma_s1, mb_s1, mc_s1;
	logic          sa_s2, sb_s2, sc_s2;
	logic [CW-1:0] ma_s2, mb_s2, mc_s2;
	logic [2*CW-1:0] bsq_s2, ac_s2;
	front_t        side_s3;
	logic [DW-1:0] disc_s3;

	logic [CW-1:0] ua, ub, uc;
	logic [DW-1:0] bsq_x, fac_x, sum_x;
	logic          ac_neg, ge;

	assign ua = din.coeff_a;
	assign ub = din.coeff_b;
	assign uc = din.coeff_c;

	assign bsq_x  = {2'b00, bsq_s2};
	assign fac_x  = {ac_s2, 2'b00};
	assign ac_neg = (sa_s2 != sc_s2) && (mc_s2 != '0);
	assign ge     = bsq_x >= fac_x;
	assign sum_x  = ac_neg ? (bsq_x + fac_x) : (bsq_x - fac_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s1 <= ua[CW-1];
			sb_s1 <= ub[CW-1];
			sc_s1 <= uc[CW-1];
			ma_s1 <= ua[CW-1] ? (~ua + 1'b1) : ua;
			mb_s1 <= ub[CW-1] ? (~ub + 1'b1) : ub;
			mc_s1 <= uc[CW-1] ? (~uc + 1'b1) : uc;

			sa_s2  <= sa_s1;
			sb_s2  <= sb_s1;
			sc_s2  <= sc_s1;
			ma_s2  <= ma_s1;
			mb_s2  <= mb_s1;
			mc_s2  <= mc_s1;
			bsq_s2 <= mb_s1 * mb_s1;
			ac_s2  <= ma_s1 * mc_s1;

			side_s3.lin   <= (ma_s2 == '0);
			side_s3.dneg  <= !ac_neg && !ge;
			side_s3.dzero <= (ac_neg || ge) && (sum_x == '0);
			side_s3.sa    <= sa_s2;
			side_s3.sb    <= sb_s2;
			side_s3.sc    <= sc_s2;
			side_s3.ma    <= ma_s2;
			side_s3.mb    <= mb_s2;
			side_s3.mc    <= mc_s2;
			disc_s3       <= (ac_neg || ge) ? sum_x : '0;
		end
	end

	assign vout = v_s3;
	assign side = side_s3;
	assign disc = disc_s3;

endmodule

// ===== rtl/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vin,
	input  qrs_pkg::front_t          side_in,
	input  logic [qrs_pkg::DW-1:0]   rad_in,
	output logic                     vout,
	output qrs_pkg::front_t          side_out,
	output logic [qrs_pkg::CW:0]     root
);
	import qrs_pkg::*;

	localparam int SQ  = CW + 1;
	localparam int RW  = CW + 3;
	localparam int RTW = CW + 1;

	logic           v_s    [SQ+1];
	front_t         side_s [SQ+1];
	logic [DW-1:0]  rad_s  [SQ+1];
	logic [RW-1:0]  rem_s  [SQ+1];
	logic [RTW-1:0] root_s [SQ+1];

	assign v_s[0]    = vin;
	assign side_s[0] = side_in;
	assign rad_s[0]  = rad_in;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < SQ; k++) begin : g_stage
		logic [RW+1:0] r;
		logic [RW-1:0] trial;
		logic          ge;

		assign r     = {rem_s[k], rad_s[k][DW-1:DW-2]};
		assign trial = {root_s[k], 2'b01};
		assign ge    = r >= {2'b00, trial};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				rad_s[k+1]  <= {rad_s[k][DW-3:0], 2'b00};
				rem_s[k+1]  <= ge ? RW'(r - {2'b00, trial}) : r[RW-1:0];
				root_s[k+1] <= {root_s[k][RTW-2:0], ge};
			end
		end
	end

	assign vout     = v_s[SQ];
	assign side_out = side_s[SQ];
	assign root     = root_s[SQ];

endmodule

// ===== rtl/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
	parameter int FRAC_BITS = qrs_pkg::FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vin,
	input  qrs_pkg::div_side_t                  side_in,
	input  logic [qrs_pkg::CW+1:0]              mag1,
	input  logic [qrs_pkg::CW+1:0]              mag2,
	input  logic [qrs_pkg::CW:0]                den,
	output logic                                vout,
	output qrs_pkg::div_side_t                  side_out,
	output logic [qrs_pkg::CW+1+FRAC_BITS:0]    quo1,
	output logic [qrs_pkg::CW+1+FRAC_BITS:0]    quo2
);
	import qrs_pkg::*;

	localparam int NW  = CW + 2 + FRAC_BITS;
	localparam int RMW = CW + 1;

	logic            v_s    [NW+1];
	div_side_t       side_s [NW+1];
	logic [RMW-1:0]  den_s  [NW+1];
	logic [NW-1:0]   n1_s   [NW+1];
	logic [NW-1:0]   n2_s   [NW+1];
	logic [RMW-1:0]  r1_s   [NW+1];
	logic [RMW-1:0]  r2_s   [NW+1];

	assign v_s[0]    = vin;
	assign side_s[0] = side_in;
	assign den_s[0]  = den;
	assign n1_s[0]   = {mag1, {FRAC_BITS{1'b0}}};
	assign n2_s[0]   = {mag2, {FRAC_BITS{1'b0}}};
	assign r1_s[0]   = '0;
	assign r2_s[0]   = '0;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [RMW:0] t1, t2;
		logic         ge1, ge2;

		assign t1  = {r1_s[k], n1_s[k][NW-1]};
		assign t2  = {r2_s[k], n2_s[k][NW-1]};
		assign ge1 = t1 >= {1'b0, den_s[k]};
		assign ge2 = t2 >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				den_s[k+1]  <= den_s[k];
				n1_s[k+1]   <= {n1_s[k][NW-2:0], ge1};
				n2_s[k+1]   <= {n2_s[k][NW-2:0], ge2};
				r1_s[k+1]   <= ge1 ? RMW'(t1 - {1'b0, den_s[k]}) : t1[RMW-1:0];
				r2_s[k+1]   <= ge2 ? RMW'(t2 - {1'b0, den_s[k]}) : t2[RMW-1:0];
			end
		end
	end

	assign vout     = v_s[NW];
	assign side_out = side_s[NW];
	assign quo1     = n1_s[NW];
	assign quo2     = n2_s[NW];

endmodule

// ===== sim/tb_quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// Self-checking bench for the fixed-point quadratic root solver.
// ----------------------------------------------------------------------------
// Drives directed corner cases, then coefficient transactions through the valid/ready
// input in random bursts and gaps, stalls the result side on its own pattern, and
// compares every result against an exact wide-integer solver of a*t^2 + b*t + c.
// ----------------------------------------------------------------------------
class root_scoreboard;
	qrs_pkg::out_t pending[$];
	int            n_err;
	int            n_seen;
	int            n_two;
	int            n_sat;

	function new();
		n_err  = 0;
		n_seen = 0;
		n_two  = 0;
		n_sat  = 0;
	endfunction

	static function logic [127:0] isqrt(logic [127:0] v);
		logic [127:0] r;
		logic [127:0] t;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			t = r | (128'd1 << k);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// magnitude * 2^16 / den truncated, signed, clamped to 32 bits
	static function logic [31:0] root_of(logic neg, logic [127:0] mag, logic [127:0] den,
			inout logic sat);
		logic [127:0] q;
		q = (mag << qrs_pkg::FRAC_DEF) / den;
		if (neg) begin
			if (q > 128'h8000_0000) begin
				q   = 128'h8000_0000;
				sat = 1'b1;
			end
			return 32'(-q);
		end
		if (q > 128'h7FFF_FFFF) begin
			q   = 128'h7FFF_FFFF;
			sat = 1'b1;
		end
		return q[31:0];
	endfunction

	function void note_coeffs(qrs_pkg::in_t t);
		qrs_pkg::out_t e;
		logic signed [127:0] a, b, c, disc, s, nm;
		logic sat;
		a   = t.coeff_a;
		b   = t.coeff_b;
		c   = t.coeff_c;
		sat = 1'b0;
		e   = '0;
		if (a == 0) begin
			if (b != 0) begin
				e.root_count = qrs_pkg::CNT_ONE;
				e.root_first = root_of((c < 0) != (b < 0) ? 1'b0 : (c != 0),
					c < 0 ? -c : c, b < 0 ? -b : b, sat);
			end
		end else begin
			disc = b * b - 4 * a * c;
			if (disc == 0) begin
				e.root_count = qrs_pkg::CNT_ONE;
				nm = -b;
				e.root_first = root_of((nm != 0) && ((nm < 0) != (a < 0)),
					nm < 0 ? -nm : nm, a < 0 ? -2 * a : 2 * a, sat);
			end else if (disc > 0) begin
				e.root_count = qrs_pkg::CNT_TWO;
				s  = isqrt(disc);
				nm = -b - s;
				e.root_first = root_of((nm != 0) && ((nm < 0) != (a < 0)),
					nm < 0 ? -nm : nm, a < 0 ? -2 * a : 2 * a, sat);
				nm = -b + s;
				e.root_second = root_of((nm != 0) && ((nm < 0) != (a < 0)),
					nm < 0 ? -nm : nm, a < 0 ? -2 * a : 2 * a, sat);
			end
		end
		e.saturated = sat;
		pending.push_back(e);
	endfunction

	function void check_roots(qrs_pkg::out_t got);
		qrs_pkg::out_t e;
		n_seen++;
		if (pending.size() == 0) begin
			$error("unexpected result transaction %h", got);
			n_err++;
			return;
		end
		e = pending.pop_front();
		if (got.root_count == qrs_pkg::CNT_TWO)
			n_two++;
		if (got.saturated)
			n_sat++;
		if (got.root_count !== e.root_count) begin
			$error("root_count: expected %0d, got %0d", e.root_count, got.root_count);
			n_err++;
		end
		if (got.root_first !== e.root_first) begin
			$error("root_first: expected %h, got %h", e.root_first, got.root_first);
			n_err++;
		end
		if (got.root_second !== e.root_second) begin
			$error("root_second: expected %h, got %h", e.root_second, got.root_second);
			n_err++;
		end
		if (got.saturated !== e.saturated) begin
			$error("saturated: expected %0b, got %0b", e.saturated, got.saturated);
			n_err++;
		end
	endfunction
endclass

module tb_quadratic_root_solver;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 72 + qrs_pkg::FRAC_DEF;
	localparam int IDLE_LIMIT = 20000;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	qrs_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	qrs_pkg::out_t out_data;

	root_scoreboard roots;
	int             n_sent;
	int             idle_cycles;
	logic           timed_out;
	logic           stall_on;

	quadratic_root_solver i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		roots       = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		n_sent      = 0;
		idle_cycles = 0;
		timed_out   = 1'b0;
		stall_on    = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			roots.check_roots(out_data);
	end

	// receiver: alternating stretches of free flow and random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_on <= ~stall_on;
			out_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send(qrs_pkg::in_t t);
		in_valid <= 1'b1;
		in_data  <= t;
		do
			@(posedge clk);
		while (!in_ready);
		roots.note_coeffs(t);
		n_sent++;
	endtask

	task automatic pause(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_abc(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		qrs_pkg::in_t t;
		t.coeff_a = a;
		t.coeff_b = b;
		t.coeff_c = c;
		send(t);
	endtask

	function automatic logic [31:0] rnd_coeff();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2047)) - 1024) <<< 16;
			2: return 32'($signed($urandom_range(0, 65535)) - 32768);
			3: return 32'($signed($urandom_range(0, 8)) - 4);
			4: return '0;
			default: return 32'($signed($urandom_range(0, 511)) - 256) <<< $urandom_range(8, 20);
		endcase
	endfunction

	task automatic send_random();
		logic [31:0] a, r1, r2;
		case ($urandom_range(0, 3))
			0: begin
				// built from chosen roots: a(t-r1)(t-r2), small integers
				a  = 32'($signed($urandom_range(0, 14)) - 7);
				r1 = 32'($signed($urandom_range(0, 40)) - 20);
				r2 = $urandom_range(0, 3) == 0 ? r1 : 32'($signed($urandom_range(0, 40)) - 20);
				if (a == 0)
					a = 1;
				send_abc(a << 16, (-a * (r1 + r2)) << 16, (a * r1 * r2) << 16);
			end
			default:
				send_abc(rnd_coeff(), rnd_coeff(), rnd_coeff());
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (roots.pending.size() != 0 && !timed_out)
			@(posedge clk);
	endtask

	initial begin
		int burst;
		@(posedge clk);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_abc(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000); // two roots 1 and 2
		send_abc(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000); // double root
		send_abc(32'h0001_0000, 32'h0, 32'h0001_0000);         // negative disc
		send_abc(32'h0, 32'h0, 32'h1234_5678);                 // degenerate
		send_abc(32'h0, 32'h0002_0000, 32'h0);                 // linear, zero root
		send_abc(32'h0, 32'h0002_0000, 32'hFFFA_0000);         // linear
		send_abc(32'h0, 32'h0000_0001, 32'h7FFF_FFFF);         // linear clamp low
		send_abc(32'h0, 32'h0000_0001, 32'h8000_0000);         // linear clamp high
		send_abc(32'h0, 32'hFFFF_0000, 32'h8000_0000);         // exact min, no clamp
		send_abc(32'h0, 32'h0001_0000, 32'h8000_0000);         // one past max, clamps high
		send_abc(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_abc(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_abc(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_abc(32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
		send_abc(32'h0000_0001, 32'h7FFF_FFFF, 32'h0);
		send_abc(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
		send_abc(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_abc(32'h0001_0000, 32'h0, 32'h0);
		send_abc(32'hFFFF_0000, 32'h0, 32'h0004_0000);
		send_abc(32'h0001_0000, 32'h0003_0000, 32'h0);
		drain();

		while (n_sent < 1700 && !timed_out) begin
			burst = $urandom_range(1, 40);
			repeat (burst)
				send_random();
			if (n_sent > 800 && n_sent < 850)
				drain();
			else if ($urandom_range(0, 2) != 0)
				pause($urandom_range(1, 12));
		end
		drain();
		repeat (LATENCY + 10) @(posedge clk);

		$display("%0d coefficient sets sent, %0d results checked (%0d with two roots, %0d clamped)",
			n_sent, roots.n_seen, roots.n_two, roots.n_sat);
		if (!timed_out && roots.n_err == 0 && roots.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out <= 1'b1;
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end
endmodule

// ===== filelist.f =====
rtl/qrs_pkg.sv
rtl/qrs_front.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
sim/tb_quadratic_root_solver.sv
